// ===== design/gtm_pkg.sv =====
// ----------------------------------------------------------------------------
// gtm_pkg
// shared types and constants of the gamepad thrust mixer
// ----------------------------------------------------------------------------
`default_nettype none

package gtm_pkg;

    // register indexes on the configuration channel
    localparam logic [1:0] CFG_SPEED_SLOW = 2'd0;
    localparam logic [1:0] CFG_SPEED_MID  = 2'd1;
    localparam logic [1:0] CFG_SPEED_FAST = 2'd2;

    localparam logic [7:0]  FULL_SCALE    = 8'd128;
    localparam logic [10:0] NEUTRAL_PULSE = 11'd1500;
    localparam logic [10:0] PULSE_MIN     = 11'd1150;
    localparam logic [10:0] PULSE_MAX     = 11'd1850;
    localparam logic [8:0]  PULSE_SPAN    = 9'd350;
    localparam logic [1:0]  SPEED_TOP     = 2'd2;

    // direction codes
    localparam logic [3:0] DIR_STOP     = 4'd0;
    localparam logic [3:0] DIR_FORWARD  = 4'd1;
    localparam logic [3:0] DIR_BACKWARD = 4'd2;
    localparam logic [3:0] DIR_RIGHT    = 4'd3;
    localparam logic [3:0] DIR_LEFT     = 4'd4;
    localparam logic [3:0] DIR_YAW_LEFT = 4'd5;
    localparam logic [3:0] DIR_YAW_RGT  = 4'd6;
    localparam logic [3:0] DIR_UP       = 4'd7;
    localparam logic [3:0] DIR_DOWN     = 4'd8;

    // one classified poll, handed from front to back
    typedef struct packed {
        logic        connected;
        logic [15:0] prod_x;     // raw * 2s, left x
        logic [15:0] prod_y;     // (255 - raw) * 2s, left y
        logic [15:0] prod_m;     // raw * 2s, right x
        logic [7:0]  limit;      // thrust limit s
        logic [10:0] pulse;      // vertical pulse for this poll
        logic [7:0]  accessory;  // accessory bits after this poll
        logic [1:0]  speed;      // speed level after this poll
    } t_work;

endpackage

`default_nettype wire

// ===== design/gamepad_thrust_mixer_top.sv =====
// ----------------------------------------------------------------------------
// gamepad_thrust_mixer_top
// turns gamepad polls into thruster commands, one result per poll
// ----------------------------------------------------------------------------
// Each poll pushed in gives exactly one result, in order. The front stage
// takes a poll, updates the speed level and accessory bits, and forms the
// stick products; a QUEUE_DEPTH entry queue hands the poll to the back
// stage. For a connected poll the back stage steps through fetch, map,
// multiply, eight iterations of the three-lane restoring divider that
// normalizes the axes, commit and present; for a connected poll whose mapped
// axes all come to zero the divider is skipped; a disconnected poll goes
// through fetch, map and present only, and changes no state. A finished
// result that has not been popped holds the back stage in its present
// state. The divider sets the sustained rate. The front keeps taking polls
// while the back works and while a finished result waits to be popped.
// Configuration writes are always accepted (ready held high) and must only
// be issued while the block is idle; a write to an index beyond the three
// speed limits is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_thrust_mixer_top
    import gtm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data,
    // poll side
    input  wire logic         push,
    output logic              full,
    input  wire logic         i_connected,
    input  wire logic [7:0]   i_left_x,
    input  wire logic [7:0]   i_left_y,
    input  wire logic [7:0]   i_right_x,
    input  wire logic [7:0]   i_toggle_clicks,
    input  wire logic         i_slower_click,
    input  wire logic         i_faster_click,
    input  wire logic         i_r2_held,
    input  wire logic         i_l2_held,
    // result side
    input  wire logic         pop,
    output logic              empty,
    output logic signed [8:0] o_sway_thrust,
    output logic signed [8:0] o_surge_thrust,
    output logic signed [8:0] o_yaw_thrust,
    output logic [10:0]       o_vertical_pulse,
    output logic [7:0]        o_accessory_bits,
    output logic [1:0]        o_speed_level,
    output logic [3:0]        o_direction_code
);

    // front to queue
    logic  q_push;
    logic  q_full;
    t_work q_in;
    // queue to back
    logic  q_pop;
    logic  q_empty;
    t_work q_out;

    // registers take a write every cycle
    assign o_cfg_ready = 1'b1;

    gtm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .o_full          (full),
        .i_connected     (i_connected),
        .i_left_x        (i_left_x),
        .i_left_y        (i_left_y),
        .i_right_x       (i_right_x),
        .i_toggle_clicks (i_toggle_clicks),
        .i_slower_click  (i_slower_click),
        .i_faster_click  (i_faster_click),
        .i_r2_held       (i_r2_held),
        .i_l2_held       (i_l2_held),
        .o_q_push        (q_push),
        .o_q_data        (q_in),
        .i_q_full        (q_full)
    );

    // decouples the front from the state-machine back
    gtm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    gtm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_data         (q_out),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_sway_thrust    (o_sway_thrust),
        .o_surge_thrust   (o_surge_thrust),
        .o_yaw_thrust     (o_yaw_thrust),
        .o_vertical_pulse (o_vertical_pulse),
        .o_accessory_bits (o_accessory_bits),
        .o_speed_level    (o_speed_level),
        .o_direction_code (o_direction_code)
    );

`ifndef SYNTHESIS
    // pulse stays within the trigger span
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_vertical_pulse >= PULSE_MIN && o_vertical_pulse <= PULSE_MAX))
        else $error("vertical pulse out of range");

    // speed level never leaves the three levels
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_speed_level <= SPEED_TOP)
        else $error("speed level out of range");

    // the up code agrees with a pulse below neutral
    a_dir_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_direction_code == DIR_UP) |-> o_vertical_pulse < NEUTRAL_PULSE)
        else $error("up code without a low pulse");

    // normalized thrusts keep within full scale
    a_thrust_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_sway_thrust >= -9'sd128 && o_sway_thrust <= 9'sd128
                    && o_surge_thrust >= -9'sd128 && o_surge_thrust <= 9'sd128
                    && o_yaw_thrust >= -9'sd128 && o_yaw_thrust <= 9'sd128))
        else $error("thrust beyond full scale");
`endif

endmodule

`default_nettype wire

// ===== design/gtm_front.sv =====
// ----------------------------------------------------------------------------
// gtm_front
// accepts polls, keeps speed level and accessory state, forms the products
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_front
    import gtm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic        i_connected,
    input  wire logic [7:0]  i_left_x,
    input  wire logic [7:0]  i_left_y,
    input  wire logic [7:0]  i_right_x,
    input  wire logic [7:0]  i_toggle_clicks,
    input  wire logic        i_slower_click,
    input  wire logic        i_faster_click,
    input  wire logic        i_r2_held,
    input  wire logic        i_l2_held,
    output logic             o_q_push,
    output t_work            o_q_data,
    input  wire logic        i_q_full
);

    logic [7:0]  r_speed_slow, r_speed_mid, r_speed_fast;
    logic [1:0]  r_speed_index, n_speed_index;
    logic [7:0]  r_accessory, n_accessory;
    logic [7:0]  r_flags, n_flags;

    // held poll
    logic        r_fv;
    logic        r_conn;
    logic [7:0]  r_lx, r_ly_inv, r_rx;
    logic [7:0]  r_limit;
    logic        r_down_cmd, r_up_cmd;

    logic        accept;
    logic [7:0]  sel_limit, limit;
    logic [7:0]  others, acc_flip;
    logic [1:0]  idx_dn;
    logic [14:0] px, py, pm;
    logic [15:0] pulse_prod;
    logic [8:0]  delta;

    assign accept   = i_push && !o_full;
    assign o_full   = r_fv && i_q_full;
    assign o_q_push = r_fv && !i_q_full;

    // thrust limit of the current level, clamped to full scale
    always_comb begin
        case (r_speed_index)
            2'd0:    sel_limit = r_speed_slow;
            2'd1:    sel_limit = r_speed_mid;
            default: sel_limit = r_speed_fast;
        endcase
        limit = (sel_limit > FULL_SCALE) ? FULL_SCALE : sel_limit;
    end

    always_comb begin
        others   = i_toggle_clicks & 8'hFE;
        acc_flip = i_toggle_clicks[0] ? ~r_accessory : r_accessory;
        n_accessory = (acc_flip & ~others) | (~r_flags & others);
        n_flags     = r_flags ^ others;
        idx_dn = (i_slower_click && r_speed_index != 2'd0) ? r_speed_index - 2'd1
                                                             : r_speed_index;
        n_speed_index = (i_faster_click && idx_dn < SPEED_TOP) ? idx_dn + 2'd1 : idx_dn;
    end

    // products for the axis mapping and the pulse offset
    always_comb begin
        px = 15'({7'd0, r_lx} * {7'd0, r_limit});
        py = 15'({7'd0, r_ly_inv} * {7'd0, r_limit});
        pm = 15'({7'd0, r_rx} * {7'd0, r_limit});
        pulse_prod = 16'({8'd0, r_limit} * {7'd0, PULSE_SPAN});
        delta = pulse_prod[15:7];

        o_q_data.connected = r_conn;
        o_q_data.prod_x    = {px, 1'b0};
        o_q_data.prod_y    = {py, 1'b0};
        o_q_data.prod_m    = {pm, 1'b0};
        o_q_data.limit     = r_limit;
        if (r_down_cmd) begin
            o_q_data.pulse = NEUTRAL_PULSE - {2'd0, delta};
        end else if (r_up_cmd) begin
            o_q_data.pulse = NEUTRAL_PULSE + {2'd0, delta};
        end else begin
            o_q_data.pulse = NEUTRAL_PULSE;
        end
        o_q_data.accessory = r_accessory;
        o_q_data.speed     = r_speed_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_slow  <= 8'd40;
            r_speed_mid   <= 8'd80;
            r_speed_fast  <= 8'd128;
            r_speed_index <= 2'd0;
            r_accessory   <= 8'd0;
            r_flags       <= 8'd0;
            r_fv          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPEED_SLOW: r_speed_slow <= i_cfg_data;
                    CFG_SPEED_MID:  r_speed_mid  <= i_cfg_data;
                    CFG_SPEED_FAST: r_speed_fast <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (accept) begin
                r_fv <= 1'b1;
                if (i_connected) begin
                    r_speed_index <= n_speed_index;
                    r_accessory   <= n_accessory;
                    r_flags       <= n_flags;
                end
            end else if (o_q_push) begin
                r_fv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_conn     <= i_connected;
            r_lx       <= i_left_x;
            r_ly_inv   <= ~i_left_y;
            r_rx       <= i_right_x;
            r_limit    <= limit;
            r_down_cmd <= i_r2_held;
            r_up_cmd   <= i_l2_held;
        end
    end

endmodule

`default_nettype wire

// ===== design/gtm_queue.sv =====
// ----------------------------------------------------------------------------
// gtm_queue
// short flop queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_queue
    import gtm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_work      i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_work      o_data,
    output logic       o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_work         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/gtm_back.sv =====
// ----------------------------------------------------------------------------
// gtm_back
// maps and normalizes the axes with a three-lane divider, holds the result
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_back
    import gtm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_work            i_q_data,
    input  wire logic        i_q_empty,
    output logic             o_q_pop,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic signed [8:0] o_sway_thrust,
    output logic signed [8:0] o_surge_thrust,
    output logic signed [8:0] o_yaw_thrust,
    output logic [10:0]      o_vertical_pulse,
    output logic [7:0]       o_accessory_bits,
    output logic [1:0]       o_speed_level,
    output logic [3:0]       o_direction_code
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAP, ST_MUL, ST_DIV, ST_FIN, ST_OUT
    } t_state;

    localparam logic signed [8:0] DIR_THRESH = 9'sd21;

    t_state              r_state;
    t_work               r_work;
    logic                r_ov;
    logic [2:0]          r_step;
    logic [7:0]          r_mag [3];
    logic                r_neg [3];
    logic [8:0]          r_sum;
    logic [8:0]          r_rem [3];
    logic [7:0]          r_quo [3];
    logic signed [8:0]   r_thrust [3];
    logic [10:0]         r_pulse;

    logic signed [8:0]   mapped [3];
    logic [7:0]          mag [3];
    logic [8:0]          sum;
    logic [14:0]         dividend [3];
    logic [9:0]          trial [3];
    logic [8:0]          n_rem [3];
    logic [7:0]          n_quo [3];
    logic signed [8:0]   n_thrust [3];
    logic [8:0]          tmag [3];
    logic [3:0]          dir;

    function automatic logic signed [8:0] map_axis(input logic [15:0] p,
                                                   input logic [7:0] s);
        logic [16:0] t;
        logic [9:0]  d;
        begin
            // floor(p / 255) for p below 65535
            t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
            d = {1'b0, t[16:8]} - {2'd0, s};
            map_axis = d[8:0];
        end
    endfunction

    function automatic logic [8:0] mag9(input logic signed [8:0] v);
        begin
            mag9 = v[8] ? 9'(-v) : v;
        end
    endfunction

    assign o_q_pop = (r_state == ST_IDLE) && !i_q_empty;
    assign o_empty = !r_ov;

    // mapping, magnitudes and their sum
    always_comb begin
        mapped[0] = map_axis(r_work.prod_x, r_work.limit);
        mapped[1] = map_axis(r_work.prod_y, r_work.limit);
        mapped[2] = map_axis(r_work.prod_m, r_work.limit);
        if (mapped[1] == -9'sd1) begin
            mapped[1] = 9'sd0;
        end
        for (int i = 0; i < 3; i++) begin
            mag[i] = 8'(mag9(mapped[i]));
        end
        sum = {1'b0, mag[0]} + {1'b0, mag[1]} + {1'b0, mag[2]};
    end

    // one restoring step per lane
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dividend[i] = 15'({7'd0, r_mag[i]} * {7'd0, r_work.limit});
            trial[i]    = {r_rem[i], r_quo[i][7]};
            if (trial[i] >= {1'b0, r_sum}) begin
                n_rem[i] = 9'(trial[i] - {1'b0, r_sum});
                n_quo[i] = {r_quo[i][6:0], 1'b1};
            end else begin
                n_rem[i] = trial[i][8:0];
                n_quo[i] = {r_quo[i][6:0], 1'b0};
            end
        end
    end

    // signed results, yaw negated
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_thrust[i] = (r_neg[i] ^ (i == 2)) ? -$signed({1'b0, r_quo[i]})
                                                 : $signed({1'b0, r_quo[i]});
            if (r_sum == 9'd0) begin
                n_thrust[i] = 9'sd0;
            end
        end
    end

    // direction from the stored thrusts and pulse
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tmag[i] = mag9(r_thrust[i]);
        end
        if (r_thrust[1] > DIR_THRESH && tmag[1] > tmag[0] && tmag[1] > tmag[2]) begin
            dir = DIR_FORWARD;
        end else if (r_thrust[1] < -DIR_THRESH && tmag[1] > tmag[0]
                     && tmag[1] > tmag[2]) begin
            dir = DIR_BACKWARD;
        end else if (r_thrust[0] > DIR_THRESH && tmag[0] > tmag[1]
                     && tmag[0] > tmag[2]) begin
            dir = DIR_RIGHT;
        end else if (r_thrust[0] < -DIR_THRESH && tmag[0] > tmag[1]
                     && tmag[0] > tmag[2]) begin
            dir = DIR_LEFT;
        end else if (r_thrust[2] > DIR_THRESH && tmag[2] > tmag[1]
                     && tmag[2] > tmag[0]) begin
            dir = DIR_YAW_LEFT;
        end else if (r_thrust[2] < -DIR_THRESH && tmag[2] > tmag[1]
                     && tmag[2] > tmag[0]) begin
            dir = DIR_YAW_RGT;
        end else if (r_pulse < NEUTRAL_PULSE) begin
            dir = DIR_UP;
        end else if (r_pulse > NEUTRAL_PULSE) begin
            dir = DIR_DOWN;
        end else begin
            dir = DIR_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_step  <= 3'd0;
            r_pulse <= NEUTRAL_PULSE;
            for (int i = 0; i < 3; i++) begin
                r_thrust[i] <= 9'sd0;
            end
        end else begin
            // in the present state a pop hands over to the next result below
            if (r_ov && i_pop && r_state != ST_OUT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_work  <= i_q_data;
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= mag[i];
                        r_neg[i] <= mapped[i][8];
                    end
                    r_sum   <= sum;
                    r_state <= r_work.connected ? ST_MUL : ST_OUT;
                end
                ST_MUL: begin
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= {2'd0, dividend[i][14:8]};
                        r_quo[i] <= dividend[i][7:0];
                    end
                    r_step  <= 3'd0;
                    r_state <= (r_sum == 9'd0) ? ST_FIN : ST_DIV;
                end
                ST_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= n_rem[i];
                        r_quo[i] <= n_quo[i];
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    for (int i = 0; i < 3; i++) begin
                        r_thrust[i] <= n_thrust[i];
                    end
                    r_pulse <= r_work.pulse;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ov || i_pop) begin
                        r_ov             <= 1'b1;
                        o_sway_thrust    <= r_thrust[0];
                        o_surge_thrust   <= r_thrust[1];
                        o_yaw_thrust     <= r_thrust[2];
                        o_vertical_pulse <= r_pulse;
                        o_accessory_bits <= r_work.accessory;
                        o_speed_level    <= r_work.speed;
                        o_direction_code <= dir;
                        r_state          <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
